### rtl/dsa_pkg.sv
// descriptor slot allocator: request kinds and result status codes
// no dependencies; used by descriptor_slot_allocator_top
package dsa_pkg;

  // request kinds carried on in_kind
  localparam logic [1:0] KIND_OPEN     = 2'd0;
  localparam logic [1:0] KIND_CLOSE    = 2'd1;
  localparam logic [1:0] KIND_LOOKUP   = 2'd2;
  localparam logic [1:0] KIND_FREE_ALL = 2'd3;

  // result status codes carried on out_status
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ALREADY_OPEN = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd2;
  localparam logic [2:0] ST_NOT_IN_USE   = 3'd3;
  localparam logic [2:0] ST_RANGE        = 3'd4;

  // fixed widths of the beat fields
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 8;
  localparam int NODE_W   = 16;
  localparam int STATUS_W = 3;

endpackage

### rtl/descriptor_slot_allocator_top.sv
// descriptor slot allocator: open scans every slot once through a single node comparator
// out_valid rises once an accepted open has passed scan (one slot per step), compare drain
// and response; close, free-all and failed lookups go straight to response, a good lookup
// via the lookup read; in_stall is high from accept until the result is in the output
// register, and response waits while a held output beat is stalled
// synchronous active-low reset frees every slot; node memory is not cleared; uses dsa_pkg
module descriptor_slot_allocator_top #(
  parameter int SLOT_COUNT = 64,
  parameter int NODE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dsa_pkg::KIND_W-1:0]    in_kind,
  input  logic [dsa_pkg::INDEX_W-1:0]   in_slot_index,
  input  logic [dsa_pkg::NODE_W-1:0]    in_node_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsa_pkg::STATUS_W-1:0]  out_status,
  output logic [dsa_pkg::INDEX_W-1:0]   out_slot_out,
  output logic [dsa_pkg::NODE_W-1:0]    out_node_out
);

  localparam int SW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [dsa_pkg::INDEX_W:0] SLOT_LIMIT = (dsa_pkg::INDEX_W + 1)'(SLOT_COUNT);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [SLOT_COUNT-1:0]   free_r;
  logic [NODE_BITS-1:0]    node_mem [SLOT_COUNT];
  logic [NODE_BITS-1:0]    rdata_r;
  logic [NODE_BITS-1:0]    node_r;
  logic [SW-1:0]           cnt_r;
  logic [SW-1:0]           free_idx_r;
  logic                    found_r;
  logic                    hit_r;
  logic                    chk_v_r;
  logic                    chk_used_r;
  logic [dsa_pkg::STATUS_W-1:0] res_status_r;
  logic [dsa_pkg::INDEX_W-1:0]  res_slot_r;
  logic [dsa_pkg::NODE_W-1:0]   res_node_r;
  logic                    out_valid_r;
  logic [dsa_pkg::STATUS_W-1:0] out_status_r;
  logic [dsa_pkg::INDEX_W-1:0]  out_slot_r;
  logic [dsa_pkg::NODE_W-1:0]   out_node_r;

  logic          in_acc;
  logic          out_free;
  logic [SW-1:0] idx_sw;
  logic          idx_ok;
  logic [SW-1:0] raddr;
  logic          hit_now;
  logic          hit_all;
  logic          mem_we;

  // handshake and request decode
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_sw   = in_slot_index[SW-1:0];
  assign idx_ok   = {1'b0, in_slot_index} < SLOT_LIMIT;

  // single comparator: checks the slot read in the previous scan cycle
  assign hit_now = chk_v_r && chk_used_r && (rdata_r == node_r);
  assign hit_all = hit_r || hit_now;
  assign raddr   = (state_r == S_SCAN) ? cnt_r : idx_sw;
  assign mem_we  = (state_r == S_DRAIN) && !hit_all && found_r;

  // node memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[free_idx_r] <= node_r;
    end
    rdata_r <= node_mem[raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == dsa_pkg::KIND_OPEN) begin
            state_nxt = S_SCAN;
          end else if (in_kind == dsa_pkg::KIND_LOOKUP && idx_ok && !free_r[idx_sw]) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_RESP;
      S_LOOK:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer datapath and slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_r     <= '1;
      found_r    <= 1'b0;
      hit_r      <= 1'b0;
      chk_v_r    <= 1'b0;
      chk_used_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_status_r <= dsa_pkg::ST_OK;
            res_slot_r   <= '0;
            res_node_r   <= '0;
            cnt_r        <= '0;
            found_r      <= 1'b0;
            hit_r        <= 1'b0;
            chk_v_r      <= 1'b0;
            node_r       <= NODE_BITS'(in_node_number);
            case (in_kind)
              dsa_pkg::KIND_OPEN: ;
              dsa_pkg::KIND_FREE_ALL: free_r <= '1;
              default: begin
                if (!idx_ok) begin
                  res_status_r <= dsa_pkg::ST_RANGE;
                end else if (free_r[idx_sw]) begin
                  res_status_r <= dsa_pkg::ST_NOT_IN_USE;
                end else if (in_kind == dsa_pkg::KIND_CLOSE) begin
                  free_r[idx_sw] <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_v_r    <= 1'b1;
          chk_used_r <= !free_r[cnt_r];
          hit_r      <= hit_all;
          if (free_r[cnt_r] && !found_r) begin
            found_r    <= 1'b1;
            free_idx_r <= cnt_r;
          end
          if (cnt_r != LAST_SLOT) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DRAIN: begin
          chk_v_r <= 1'b0;
          if (hit_all) begin
            res_status_r <= dsa_pkg::ST_ALREADY_OPEN;
          end else if (found_r) begin
            res_status_r       <= dsa_pkg::ST_OK;
            res_slot_r         <= dsa_pkg::INDEX_W'(free_idx_r);
            free_r[free_idx_r] <= 1'b0;
          end else begin
            res_status_r <= dsa_pkg::ST_TABLE_FULL;
          end
        end
        S_LOOK: begin
          res_node_r <= dsa_pkg::NODE_W'(rdata_r);
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_node_r   <= res_node_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_node_out = out_node_r;

  // free-all leaves every slot free
  a_free_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == dsa_pkg::KIND_FREE_ALL) |=> (&free_r))
    else $error("free-all left a slot in use");

  // a claimed slot is always one that was free
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> free_r[free_idx_r])
    else $error("open claimed a used slot");

  // a nonzero node only comes with a good lookup
  a_node_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_node_r != '0) |-> (out_status_r == dsa_pkg::ST_OK && out_slot_r == '0))
    else $error("node returned on a failed or non-lookup beat");

  // the scan ends right after the last slot
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cnt_r == LAST_SLOT) |=> (state_r == S_DRAIN))
    else $error("scan did not end after the last slot");

endmodule

### test/descriptor_slot_allocator_top_tb.sv
// testbench for descriptor_slot_allocator_top: directed and random open, close, lookup and
// free-all beats checked against a slot table predictor held in a small scoreboard class
// depends on dsa_pkg and descriptor_slot_allocator_top
module descriptor_slot_allocator_top_tb;

  localparam int SLOTS        = 64;
  localparam int NODE_BITS    = 16;
  localparam int PHASE_ITEMS  = 550;
  localparam int DRAIN_CYCLES = SLOTS + 16;
  localparam int STUCK_LIMIT  = 4000;

  // slot table predictor and queue of results still owed by the block
  class slot_table_checker;
    typedef struct packed {
      logic [dsa_pkg::STATUS_W-1:0] status;
      logic [dsa_pkg::INDEX_W-1:0]  slot;
      logic [dsa_pkg::NODE_W-1:0]   node;
    } slot_result_t;

    bit                   used[SLOTS];
    logic [NODE_BITS-1:0] node_of[SLOTS];
    slot_result_t         pending_results[$];
    int                   mismatch_count;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // apply one request beat to the table and queue its result
    function void note_request(logic [dsa_pkg::KIND_W-1:0] kind,
                               logic [dsa_pkg::INDEX_W-1:0] idx,
                               logic [dsa_pkg::NODE_W-1:0] node_in);
      slot_result_t         r;
      logic [NODE_BITS-1:0] node;
      bit                   held;
      int                   lowest;
      r = '0;
      r.status = dsa_pkg::ST_OK;
      node = node_in[NODE_BITS-1:0];
      if (kind == dsa_pkg::KIND_OPEN) begin
        held = 1'b0;
        lowest = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (used[i] && node_of[i] == node) held = 1'b1;
          if (!used[i] && lowest < 0) lowest = i;
        end
        if (held) begin
          r.status = dsa_pkg::ST_ALREADY_OPEN;
        end else if (lowest < 0) begin
          r.status = dsa_pkg::ST_TABLE_FULL;
        end else begin
          used[lowest] = 1'b1;
          node_of[lowest] = node;
          r.slot = dsa_pkg::INDEX_W'(lowest);
        end
      end else if (kind == dsa_pkg::KIND_FREE_ALL) begin
        foreach (used[i]) used[i] = 1'b0;
      end else if (int'(idx) >= SLOTS) begin
        r.status = dsa_pkg::ST_RANGE;
      end else if (!used[idx]) begin
        r.status = dsa_pkg::ST_NOT_IN_USE;
      end else if (kind == dsa_pkg::KIND_CLOSE) begin
        used[idx] = 1'b0;
      end else begin
        r.node = dsa_pkg::NODE_W'(node_of[idx]);
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
    endtask

    // compare one result beat with the oldest owed result
    task check_result(logic [dsa_pkg::STATUS_W-1:0] status,
                      logic [dsa_pkg::INDEX_W-1:0] slot,
                      logic [dsa_pkg::NODE_W-1:0] node);
      slot_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none owed, status", 32'(status), 32'(0));
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
      if (slot !== want.slot) report_mismatch("slot_out", 32'(slot), 32'(want.slot));
      if (node !== want.node) report_mismatch("node_out", 32'(node), 32'(want.node));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [dsa_pkg::KIND_W-1:0]    in_kind = dsa_pkg::KIND_OPEN;
  logic [dsa_pkg::INDEX_W-1:0]   in_slot_index = '0;
  logic [dsa_pkg::NODE_W-1:0]    in_node_number = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [dsa_pkg::STATUS_W-1:0]  out_status;
  logic [dsa_pkg::INDEX_W-1:0]   out_slot_out;
  logic [dsa_pkg::NODE_W-1:0]    out_node_out;

  slot_table_checker             sb = new();
  int                            send_idle_pct = 38;
  int                            recv_idle_pct = 85;
  int                            items_sent = 0;
  int                            stuck_cycles = 0;
  logic [dsa_pkg::NODE_W-1:0]    node_pool[16];

  descriptor_slot_allocator_top #(
    .SLOT_COUNT(SLOTS),
    .NODE_BITS (NODE_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_slot_index (in_slot_index),
    .in_node_number(in_node_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_slot_out  (out_slot_out),
    .out_node_out  (out_node_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // beat monitor, receiver stall and count of cycles without progress
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_status, out_slot_out, out_node_out);
    end
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_kind, in_slot_index, in_node_number);
    end
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall))) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // optional idle gap, then present one request beat and hold it until taken
  task automatic send_request(logic [dsa_pkg::KIND_W-1:0] kind,
                              logic [dsa_pkg::INDEX_W-1:0] idx,
                              logic [dsa_pkg::NODE_W-1:0] node);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_slot_index <= idx;
    in_node_number <= node;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // mostly valid slots, some out of range ones
  function automatic logic [dsa_pkg::INDEX_W-1:0] rand_slot();
    int r;
    r = $urandom_range(99);
    if (r < 75) return dsa_pkg::INDEX_W'($urandom_range(SLOTS - 1));
    if (r < 90) return dsa_pkg::INDEX_W'($urandom_range(255, SLOTS));
    return dsa_pkg::INDEX_W'($urandom_range(255));
  endfunction

  // half the nodes come from a small pool so reopens hit held nodes
  function automatic logic [dsa_pkg::NODE_W-1:0] pick_node();
    if ($urandom_range(1) == 0) return node_pool[$urandom_range(15)];
    return dsa_pkg::NODE_W'($urandom);
  endfunction

  // enough opens to fill the table and run into the full case
  task automatic fill_table();
    repeat (SLOTS + 2) send_request(dsa_pkg::KIND_OPEN, rand_slot(), dsa_pkg::NODE_W'($urandom));
  endtask

  task automatic mixed_requests(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40) send_request(dsa_pkg::KIND_OPEN, rand_slot(), pick_node());
      else if (r < 65) send_request(dsa_pkg::KIND_CLOSE, rand_slot(), pick_node());
      else if (r < 96) send_request(dsa_pkg::KIND_LOOKUP, rand_slot(), pick_node());
      else send_request(dsa_pkg::KIND_FREE_ALL, rand_slot(), pick_node());
    end
  endtask

  task automatic random_phase(int count);
    int target;
    target = items_sent + count;
    node_pool[0] = '0;
    node_pool[1] = '1;
    for (int i = 2; i < 16; i++) node_pool[i] = dsa_pkg::NODE_W'($urandom);
    fill_table();
    while (items_sent < target) begin
      if ($urandom_range(5) == 0) fill_table();
      else mixed_requests(20);
    end
  endtask

  // edge cases on an empty and a lightly used table
  task automatic directed_requests();
    send_request(dsa_pkg::KIND_LOOKUP, 8'd0, 16'h0000);
    send_request(dsa_pkg::KIND_CLOSE, 8'd0, 16'hffff);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd63, 16'h0000);
    send_request(dsa_pkg::KIND_CLOSE, 8'd64, 16'h0000);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd255, 16'hffff);
    send_request(dsa_pkg::KIND_OPEN, 8'd255, 16'h0000);
    send_request(dsa_pkg::KIND_OPEN, 8'd0, 16'hffff);
    send_request(dsa_pkg::KIND_OPEN, 8'd1, 16'h0000);
    send_request(dsa_pkg::KIND_OPEN, 8'd0, 16'hffff);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd0, 16'hffff);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd1, 16'h0000);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd2, 16'h0000);
    send_request(dsa_pkg::KIND_CLOSE, 8'd0, 16'h5555);
    send_request(dsa_pkg::KIND_CLOSE, 8'd0, 16'h0000);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd0, 16'h0000);
    send_request(dsa_pkg::KIND_OPEN, 8'd170, 16'h1234);
    send_request(dsa_pkg::KIND_OPEN, 8'd85, 16'h8000);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd2, 16'haaaa);
    send_request(dsa_pkg::KIND_CLOSE, 8'd128, 16'h0000);
    send_request(dsa_pkg::KIND_FREE_ALL, 8'd255, 16'hffff);
    send_request(dsa_pkg::KIND_LOOKUP, 8'd1, 16'h0000);
    send_request(dsa_pkg::KIND_OPEN, 8'd0, 16'hffff);
    send_request(dsa_pkg::KIND_FREE_ALL, 8'd0, 16'h0000);
  endtask

  // reset, directed beats, three random phases, then drain
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    directed_requests();
    random_phase(PHASE_ITEMS);
    send_idle_pct = 85;
    recv_idle_pct = 38;
    random_phase(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/dsa_pkg.sv
rtl/descriptor_slot_allocator_top.sv
test/descriptor_slot_allocator_top_tb.sv
